@@ sv/midi_cc_control_mapper_defines.svh @@
// Assertion macros for the MIDI CC mapper.
`ifndef MIDI_CC_CONTROL_MAPPER_DEFINES_SVH
`define MIDI_CC_CONTROL_MAPPER_DEFINES_SVH

`ifndef ASSERT_OFF

`define MCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MCM_ASSERT_NOW(label, ante, cons)

`define MCM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ sv/mcm_pkg.sv @@
package mcm_pkg;

    localparam int LANE_PAGES = 7;
    localparam logic [2:0] GLOBAL_PAGE = 3'd7;

    localparam logic [2:0] ST_IGNORED    = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_CONTINUOUS = 3'd3;
    localparam logic [2:0] ST_PRESS      = 3'd4;
    localparam logic [2:0] ST_RELEASE    = 3'd5;
    localparam logic [2:0] ST_HOLD       = 3'd6;
    localparam logic [2:0] ST_NOOP       = 3'd7;

    localparam logic [5:0] CODE_NONE       = 6'd0;
    localparam logic [5:0] CODE_VOICE      = 6'd1;
    localparam logic [5:0] CODE_ROUTE      = 6'd9;
    localparam logic [5:0] CODE_TIMING     = 6'd17;
    localparam logic [5:0] CODE_GFX        = 6'd25;
    localparam logic [5:0] CODE_BPM        = 6'd33;
    localparam logic [5:0] CODE_MASTER     = 6'd34;
    localparam logic [5:0] CODE_UNASSIGNED = 6'd35;
    localparam logic [5:0] CODE_PAGE       = 6'd36;
    localparam logic [5:0] CODE_GLOBAL     = 6'd43;
    localparam logic [5:0] CODE_CLEAR      = 6'd44;
    localparam logic [5:0] CODE_TOGGLE     = 6'd45;

    localparam logic [0:0] REG_LISTEN = 1'b0;
    localparam logic [4:0] LISTEN_RESET = 5'd16;

    localparam int CcMax = 127;
    localparam int RouteSpan = 63;
    localparam int TempoScale = 1000;

    localparam int TBL_UNIT   = 0;
    localparam int TBL_ROUTE  = 1;
    localparam int TBL_GAIN   = 2;
    localparam int TBL_ENGINE = 3;
    localparam int TBL_ROOT   = 4;
    localparam int TBL_BPM    = 5;
    localparam int TBL_DIV16  = 6;
    localparam int TBL_DIV64  = 7;

    typedef logic [15:0] t_tbl [128];

    typedef struct packed {
        logic [2:0]  page;
        logic        lane_mode;
        logic [7:0]  button_down;
        logic [15:0] clear_gen;
    } t_state;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         control_code;
        logic [2:0]         button_page;
        logic [7:0]         step_value;
        logic [8:0]         whole_value;
        logic signed [15:0] level_q8_8;
        logic               dispatched;
        logic [2:0]         page_now;
        logic               lane_mode_now;
        logic [15:0]        clear_count;
        logic [18:0]        tempo_milli;
    } t_result;

    function automatic t_tbl build_tbl(input int kind);
        t_tbl tbl;
        int   q;
        for (int i = 0; i < 128; i++) begin
            q = 0;
            case (kind)
                TBL_UNIT:   q = (i * 256 + 63) / CcMax;
                TBL_GAIN:   q = 24 * 256 + (i * 72 * 256 + 63) / CcMax;
                TBL_ENGINE: q = (i * 23 + 63) / CcMax;
                TBL_ROOT:   q = 24 + (i * 60 + 63) / CcMax;
                TBL_BPM:    q = 20 + (i * 280 + 63) / CcMax;
                TBL_DIV16:  q = (i * 16 + 63) / CcMax;
                TBL_DIV64:  q = (i == 0) ? 0 : 1 + ((i - 1) * 64) / CcMax;
                TBL_ROUTE: begin
                    if (i >= 64) begin
                        q = ((i - 64) * 256 + 31) / RouteSpan;
                        if (q > 256) q = 256;
                    end else begin
                        q = ((64 - i) * 256 + 31) / RouteSpan;
                        if (q > 256) q = 256;
                        q = -q;
                    end
                end
                default: q = 0;
            endcase
            tbl[i] = 16'(q);
        end
        return tbl;
    endfunction

    localparam t_tbl UNIT_TBL   = build_tbl(TBL_UNIT);
    localparam t_tbl ROUTE_TBL  = build_tbl(TBL_ROUTE);
    localparam t_tbl GAIN_TBL   = build_tbl(TBL_GAIN);
    localparam t_tbl ENGINE_TBL = build_tbl(TBL_ENGINE);
    localparam t_tbl ROOT_TBL   = build_tbl(TBL_ROOT);
    localparam t_tbl BPM_TBL    = build_tbl(TBL_BPM);
    localparam t_tbl DIV16_TBL  = build_tbl(TBL_DIV16);
    localparam t_tbl DIV64_TBL  = build_tbl(TBL_DIV64);

endpackage

@@ sv/mcm_map.sv @@
module mcm_map (
    input  logic [4:0]      i_listen,
    input  logic [4:0]      i_channel,
    input  logic [7:0]      i_controller,
    input  logic [7:0]      i_amount,
    input  mcm_pkg::t_state i_state,
    output mcm_pkg::t_result o_result,
    output mcm_pkg::t_state  o_next_state
);

    logic [6:0] v7;
    logic [7:0] enc_off;
    logic [7:0] tim_off;
    logic [2:0] idx;
    logic [2:0] tidx;
    logic [2:0] bpage;
    logic       lane_page;
    logic       global_page;

    assign v7          = i_amount[6:0];
    assign enc_off     = i_controller - 8'd20;
    assign tim_off     = i_controller - 8'd28;
    assign idx         = enc_off[2:0];
    assign tidx        = tim_off[2:0];
    assign bpage       = i_controller[2:0];
    assign lane_page   = i_state.page < 3'(mcm_pkg::LANE_PAGES);
    assign global_page = i_state.page == mcm_pkg::GLOBAL_PAGE;

    always_comb begin
        mcm_pkg::t_result r;
        mcm_pkg::t_state  ns;
        r  = '0;
        ns = i_state;

        if (i_channel != i_listen) begin
            r.status = mcm_pkg::ST_IGNORED;
        end else if (i_controller[7] || i_amount[7]) begin
            r.status = mcm_pkg::ST_INVALID;
        end else if (i_controller >= 8'd20 && i_controller <= 8'd27) begin
            r.status     = mcm_pkg::ST_CONTINUOUS;
            r.step_value = 8'(idx);
            if (lane_page) begin
                r.dispatched = 1'b1;
                if (!i_state.lane_mode) begin
                    r.control_code = mcm_pkg::CODE_VOICE + 6'(idx);
                    if (idx == 3'd0) begin
                        r.step_value  = mcm_pkg::ENGINE_TBL[v7][7:0];
                        r.whole_value = mcm_pkg::ENGINE_TBL[v7][8:0];
                    end else if (idx == 3'd1) begin
                        r.level_q8_8 = mcm_pkg::GAIN_TBL[v7];
                    end else begin
                        r.level_q8_8 = mcm_pkg::UNIT_TBL[v7];
                    end
                end else begin
                    r.control_code = mcm_pkg::CODE_ROUTE + 6'(idx);
                    if (idx == 3'd0) r.level_q8_8 = v7[6] ? 16'sd256 : 16'sd0;
                    else r.level_q8_8 = mcm_pkg::ROUTE_TBL[v7];
                end
            end else begin
                r.control_code = mcm_pkg::CODE_GFX + 6'(idx);
                r.dispatched   = global_page;
                if (idx == 3'd2) begin
                    r.step_value  = mcm_pkg::ROOT_TBL[v7][7:0];
                    r.whole_value = mcm_pkg::ROOT_TBL[v7][8:0];
                end else begin
                    r.level_q8_8 = mcm_pkg::UNIT_TBL[v7];
                end
            end
        end else if (i_controller >= 8'd28 && i_controller <= 8'd35) begin
            if (global_page) begin
                if (tidx == 3'd0) begin
                    r.status       = mcm_pkg::ST_CONTINUOUS;
                    r.control_code = mcm_pkg::CODE_BPM;
                    r.whole_value  = mcm_pkg::BPM_TBL[v7][8:0];
                    r.tempo_milli  = 19'(mcm_pkg::BPM_TBL[v7][8:0])
                                   * 19'(mcm_pkg::TempoScale);
                    r.dispatched   = 1'b1;
                end else if (tidx == 3'd1) begin
                    r.status       = mcm_pkg::ST_CONTINUOUS;
                    r.control_code = mcm_pkg::CODE_MASTER;
                    r.level_q8_8   = mcm_pkg::UNIT_TBL[v7];
                    r.dispatched   = 1'b1;
                end else begin
                    r.status       = mcm_pkg::ST_NOOP;
                    r.control_code = mcm_pkg::CODE_UNASSIGNED;
                end
            end else begin
                r.status       = mcm_pkg::ST_CONTINUOUS;
                r.control_code = mcm_pkg::CODE_TIMING + 6'(tidx);
                r.dispatched   = lane_page;
                case (tidx)
                    3'd0: r.step_value = 8'(v7[6:3]);
                    3'd1: begin
                        r.step_value = 8'(v7);
                        r.level_q8_8 = 16'({v7, 1'b0});
                    end
                    3'd2: r.step_value = 8'(v7[6:4]);
                    3'd3: r.step_value = mcm_pkg::DIV16_TBL[v7][7:0];
                    3'd4: r.step_value = 8'(v7[6:3]);
                    3'd6: r.step_value = mcm_pkg::DIV64_TBL[v7][7:0];
                    default: r.level_q8_8 = mcm_pkg::UNIT_TBL[v7];
                endcase
            end
        end else if (i_controller >= 8'd40 && i_controller <= 8'd47) begin
            r.button_page = bpage;
            if (bpage != 3'd7) begin
                r.control_code = (bpage == i_state.page) ? mcm_pkg::CODE_TOGGLE
                                                          : mcm_pkg::CODE_PAGE + 6'(bpage);
            end else begin
                r.control_code = global_page ? mcm_pkg::CODE_CLEAR : mcm_pkg::CODE_GLOBAL;
            end
            if (v7 == 7'd0) begin
                r.status              = mcm_pkg::ST_RELEASE;
                ns.button_down[bpage] = 1'b0;
            end else if (i_state.button_down[bpage]) begin
                r.status = mcm_pkg::ST_HOLD;
            end else begin
                r.status              = mcm_pkg::ST_PRESS;
                ns.button_down[bpage] = 1'b1;
                if (r.control_code == mcm_pkg::CODE_GLOBAL) begin
                    ns.page      = mcm_pkg::GLOBAL_PAGE;
                    r.dispatched = 1'b1;
                end else if (r.control_code == mcm_pkg::CODE_CLEAR) begin
                    ns.clear_gen = i_state.clear_gen + 16'd1;
                    r.dispatched = 1'b1;
                end else if (r.control_code == mcm_pkg::CODE_TOGGLE) begin
                    if (lane_page) begin
                        ns.lane_mode = ~i_state.lane_mode;
                        r.dispatched = 1'b1;
                    end
                end else begin
                    ns.page      = bpage;
                    r.dispatched = 1'b1;
                end
            end
        end else begin
            r.status = mcm_pkg::ST_UNKNOWN;
        end

        r.page_now      = ns.page;
        r.lane_mode_now = ns.lane_mode;
        r.clear_count   = ns.clear_gen;
        o_result        = r;
        o_next_state    = ns;
    end

endmodule

@@ sv/mcm_state.sv @@
module mcm_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_update,
    input  mcm_pkg::t_state i_next,
    output mcm_pkg::t_state o_state
);

    mcm_pkg::t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_update) begin
            r_state <= i_next;
        end
    end

    assign o_state = r_state;

endmodule

@@ sv/midi_cc_control_mapper.sv @@
// MIDI control-change mapper. Takes one control change per beat on s_axis and
// returns one mapped result per beat on m_axis. Throughput is one beat per
// clock while m_axis_tready holds; the input register and the result
// register sit around a single pass of table lookups and compares. Page, lane
// mode, button-down bits and the clear counter update at the edge the result
// is registered, so the next beat sees them. s_axis_tready follows
// m_axis_tready combinationally. listen_channel (reset 16) sits at APB
// address 0; write it only while no beat is in flight.
`include "midi_cc_control_mapper_defines.svh"

module midi_cc_control_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // channel[4:0], controller[12:5], amount[20:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], control_code[8:3], button_page[11:9], step_value[19:12],
    // whole_value[28:20], level_q8_8[44:29], dispatched[45], page_now[48:46],
    // lane_mode_now[49], clear_count[65:50], tempo_milli[84:66]
    output logic [87:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             r_in_valid;
    logic             n_in_valid;
    logic [4:0]       r_in_channel;
    logic [7:0]       r_in_controller;
    logic [7:0]       r_in_amount;
    logic             r_out_valid;
    logic             n_out_valid;
    mcm_pkg::t_result r_out;
    logic [4:0]       r_listen;

    logic             s_accept;
    logic             advance;
    mcm_pkg::t_state  state;
    mcm_pkg::t_state  next_state;
    mcm_pkg::t_result result;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign n_in_valid  = s_accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = advance ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the beat until the map stage takes it
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_channel    <= s_axis_tdata[4:0];
            r_in_controller <= s_axis_tdata[12:5];
            r_in_amount     <= s_axis_tdata[20:13];
        end
        if (advance) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen <= mcm_pkg::LISTEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mcm_pkg::REG_LISTEN) begin
            r_listen <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mcm_pkg::REG_LISTEN) ? 32'(r_listen) : 32'd0;

    mcm_map u_map (
        .i_listen     (r_listen),
        .i_channel    (r_in_channel),
        .i_controller (r_in_controller),
        .i_amount     (r_in_amount),
        .i_state      (state),
        .o_result     (result),
        .o_next_state (next_state)
    );

    mcm_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_next   (next_state),
        .o_state  (state)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.tempo_milli, r_out.clear_count, r_out.lane_mode_now,
                            r_out.page_now, r_out.dispatched, r_out.level_q8_8,
                            r_out.whole_value, r_out.step_value, r_out.button_page,
                            r_out.control_code, r_out.status};

    `MCM_ASSERT_NEXT(a_state_moves_on_advance, !advance, $stable(state))
    `MCM_ASSERT_NOW(a_in_reg_not_overwritten, r_in_valid && !advance, !s_axis_tready)
    `MCM_ASSERT_NOW(a_tempo_only_for_bpm, r_out_valid && r_out.tempo_milli != 19'd0, r_out.control_code == mcm_pkg::CODE_BPM && r_out.dispatched)
    `MCM_ASSERT_NOW(a_page_select_lands, r_out_valid && r_out.dispatched && r_out.control_code >= mcm_pkg::CODE_PAGE && r_out.control_code < mcm_pkg::CODE_GLOBAL, r_out.page_now == r_out.button_page)

endmodule
